// File: hw/rtl/dnsqx_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// dnsqx_pkg
// Shared types and protocol constants for the DNS query name extractor.
// ---------------------------------------------------------------------------
package dnsqx_pkg;

	// configuration port
	localparam int unsigned APB_ADDR_BITS = 3;
	localparam int unsigned APB_DATA_BITS = 32;
	localparam logic        REG_DNS_PORT  = 1'b0;   // register index, paddr[2]
	localparam logic [15:0] DNS_PORT_RESET = 16'd53;

	// Ethernet / IPv4 / UDP / DNS layout
	localparam int unsigned ETH_HDR_BYTES   = 14;
	localparam int unsigned ETH_TYPE_HI_POS = 12;
	localparam int unsigned ETH_TYPE_LO_POS = 13;
	localparam logic [7:0]  ETYPE_IPV4_HI   = 8'h08;
	localparam logic [7:0]  ETYPE_IPV4_LO   = 8'h00;

	localparam int unsigned IP_IHL_MIN      = 20;
	localparam int unsigned IP_PROTO_OFF    = 9;
	localparam int unsigned IP_SRC_FIRST    = 12;
	localparam int unsigned IP_SRC_LAST     = 15;
	localparam logic [7:0]  IP_PROTO_UDP    = 8'd17;

	localparam int unsigned UDP_HDR_BYTES   = 8;
	localparam int unsigned UDP_DPORT_HI    = 2;
	localparam int unsigned UDP_DPORT_LO    = 3;

	localparam int unsigned DNS_HDR_BYTES   = 12;
	localparam int unsigned DNS_FLAGS_OFF   = 2;
	localparam int unsigned DNS_QDCNT_HI    = 4;
	localparam int unsigned DNS_QDCNT_LO    = 5;
	localparam logic [7:0]  DNS_QR_MASK     = 8'h80;

	localparam logic [2:0]  TRAILER_BYTES   = 3'd4;
	localparam logic [7:0]  NAME_DOT        = 8'd46;

	// stream payload widths
	localparam int unsigned OUT_TDATA_BITS  = 56;
	localparam int unsigned OUT_TUSER_BITS  = 2;

	// one result item
	typedef struct packed {
		logic        valid;
		logic [7:0]  name_byte;
		logic        byte_valid;
		logic        name_end;
		logic        truncated;
		logic [31:0] source_ip;
		logic [15:0] question_index;
	} result_t;

endpackage
`default_nettype wire

// File: hw/rtl/dnsqx_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// dnsqx_cfg
// APB register file: holds the UDP destination port that marks DNS.
// ---------------------------------------------------------------------------
module dnsqx_cfg
	import dnsqx_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     psel,
	input  wire logic                     penable,
	input  wire logic                     pwrite,
	input  wire logic [APB_ADDR_BITS-1:0] paddr,
	input  wire logic [APB_DATA_BITS-1:0] pwdata,
	output logic      [APB_DATA_BITS-1:0] prdata,
	output logic                          pready,
	output logic      [15:0]              dns_port
);

	logic [15:0] dns_port_q;
	logic        wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_DNS_PORT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dns_port_q <= DNS_PORT_RESET;
		end else if (wr_en) begin
			dns_port_q <= pwdata[15:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_DNS_PORT) begin
			prdata = {{(APB_DATA_BITS-16){1'b0}}, dns_port_q};
		end
	end

	assign dns_port = dns_port_q;

endmodule
`default_nettype wire

// File: hw/rtl/dnsqx_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// dnsqx_parser
// Per-byte frame parser: header checks, question walk, name result.
// ---------------------------------------------------------------------------
module dnsqx_parser
	import dnsqx_pkg::*;
#(
	parameter int unsigned POSITION_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        step,       // byte consumed this cycle
	input  wire logic [7:0]  frame_byte,
	input  wire logic        frame_end,
	input  wire logic [15:0] dns_port,
	output result_t          result      // valid only together with step
);

	typedef enum logic [2:0] {
		PH_ETH,
		PH_IP,
		PH_UDP,
		PH_DNSH,
		PH_NLEN,
		PH_NCHR,
		PH_TRAIL,
		PH_DONE
	} phase_t;

	localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

	phase_t                   phase_q, phase_d;
	logic [POSITION_BITS-1:0] pos_q;
	logic [5:0]               ihl_q, ihl_d;
	logic [31:0]              src_q, src_d;
	logic [15:0]              dport_q, dport_d;
	logic [15:0]              qleft_q, qleft_d;
	logic [7:0]               label_q, label_d;
	logic [2:0]               trail_q, trail_d;
	logic [15:0]              qnum_q, qnum_d;
	logic                     first_q, first_d;

	logic [POSITION_BITS-1:0] off_ip, off_udp, off_dns;
	logic [7:0]               label_dec;
	logic [2:0]               trail_dec;
	logic                     emit_char, emit_dot, emit_end;
	logic                     in_name, trunc;

	assign off_ip  = pos_q - POSITION_BITS'(ETH_HDR_BYTES);
	assign off_udp = off_ip - POSITION_BITS'(ihl_q);
	assign off_dns = off_udp - POSITION_BITS'(UDP_HDR_BYTES);
	assign label_dec = label_q - 8'd1;
	assign trail_dec = trail_q - 3'd1;

	always_comb begin
		phase_d   = phase_q;
		ihl_d     = ihl_q;
		src_d     = src_q;
		dport_d   = dport_q;
		qleft_d   = qleft_q;
		label_d   = label_q;
		trail_d   = trail_q;
		qnum_d    = qnum_q;
		first_d   = first_q;
		emit_char = 1'b0;
		emit_dot  = 1'b0;
		emit_end  = 1'b0;

		case (phase_q)
			PH_ETH: begin
				if (pos_q == POSITION_BITS'(ETH_TYPE_HI_POS) && frame_byte != ETYPE_IPV4_HI) begin
					phase_d = PH_DONE;
				end else if (pos_q == POSITION_BITS'(ETH_TYPE_LO_POS)) begin
					phase_d = (frame_byte != ETYPE_IPV4_LO) ? PH_DONE : PH_IP;
				end
			end
			PH_IP: begin
				if (off_ip == '0) begin
					ihl_d = {frame_byte[3:0], 2'b00};
				end
				if (off_ip == '0 && ihl_d < 6'(IP_IHL_MIN)) begin
					phase_d = PH_DONE;
				end else if (off_ip == POSITION_BITS'(IP_PROTO_OFF)
						&& frame_byte != IP_PROTO_UDP) begin
					phase_d = PH_DONE;
				end else begin
					if (off_ip >= POSITION_BITS'(IP_SRC_FIRST)
							&& off_ip <= POSITION_BITS'(IP_SRC_LAST)) begin
						src_d = {src_q[23:0], frame_byte};
					end
					if (off_ip + POSITION_BITS'(1) == POSITION_BITS'(ihl_d)) begin
						phase_d = PH_UDP;
					end
				end
			end
			PH_UDP: begin
				if (off_udp == POSITION_BITS'(UDP_DPORT_HI)) begin
					dport_d = {frame_byte, 8'h00};
				end else if (off_udp == POSITION_BITS'(UDP_DPORT_LO)) begin
					dport_d = {dport_q[15:8], frame_byte};
					if (dport_d != dns_port) begin
						phase_d = PH_DONE;
					end
				end else if (off_udp == POSITION_BITS'(UDP_HDR_BYTES - 1)) begin
					phase_d = PH_DNSH;
				end
			end
			PH_DNSH: begin
				if (off_dns == POSITION_BITS'(DNS_FLAGS_OFF)
						&& (frame_byte & DNS_QR_MASK) != 8'h00) begin
					phase_d = PH_DONE;
				end else if (off_dns == POSITION_BITS'(DNS_QDCNT_HI)) begin
					qleft_d = {frame_byte, 8'h00};
				end else if (off_dns == POSITION_BITS'(DNS_QDCNT_LO)) begin
					qleft_d = {qleft_q[15:8], frame_byte};
				end else if (off_dns == POSITION_BITS'(DNS_HDR_BYTES - 1)) begin
					first_d = 1'b1;
					phase_d = (qleft_q != '0) ? PH_NLEN : PH_DONE;
				end
			end
			PH_NLEN: begin
				if (frame_byte == 8'h00) begin
					emit_end = 1'b1;
					qnum_d   = qnum_q + 16'd1;
					qleft_d  = qleft_q - 16'd1;
					trail_d  = TRAILER_BYTES;
					first_d  = 1'b1;
					phase_d  = PH_TRAIL;
				end else begin
					label_d  = frame_byte;
					emit_dot = !first_q;
					first_d  = 1'b0;
					phase_d  = PH_NCHR;
				end
			end
			PH_NCHR: begin
				emit_char = 1'b1;
				label_d   = label_dec;
				if (label_dec == '0) begin
					phase_d = PH_NLEN;
				end
			end
			PH_TRAIL: begin
				trail_d = trail_dec;
				if (trail_dec == '0) begin
					phase_d = (qleft_q != '0) ? PH_NLEN : PH_DONE;
				end
			end
			default: begin
			end
		endcase
	end

	// a frame that stops inside a name still closes it
	assign in_name = (phase_d == PH_NCHR) || (phase_d == PH_NLEN && !first_d);
	assign trunc   = frame_end && !emit_end && in_name;

	always_comb begin
		result                = '0;
		result.valid          = emit_char || emit_dot || emit_end || (frame_end && in_name);
		result.source_ip      = src_q;
		result.question_index = qnum_q;
		result.truncated      = trunc;
		result.name_end       = emit_end || trunc;
		if (emit_char) begin
			result.name_byte  = frame_byte;
			result.byte_valid = 1'b1;
		end else if (emit_dot && !trunc) begin
			result.name_byte  = NAME_DOT;
			result.byte_valid = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_ETH;
			pos_q   <= '0;
			ihl_q   <= '0;
			src_q   <= '0;
			dport_q <= '0;
			qleft_q <= '0;
			label_q <= '0;
			trail_q <= '0;
			qnum_q  <= '0;
			first_q <= 1'b1;
		end else if (step) begin
			if (frame_end) begin
				phase_q <= PH_ETH;
				pos_q   <= '0;
				ihl_q   <= '0;
				src_q   <= '0;
				dport_q <= '0;
				qleft_q <= '0;
				label_q <= '0;
				trail_q <= '0;
				qnum_q  <= '0;
				first_q <= 1'b1;
			end else begin
				phase_q <= phase_d;
				if (pos_q != POS_MAX) begin
					pos_q <= pos_q + POSITION_BITS'(1);
				end
				ihl_q   <= ihl_d;
				src_q   <= src_d;
				dport_q <= dport_d;
				qleft_q <= qleft_d;
				label_q <= label_d;
				trail_q <= trail_d;
				qnum_q  <= qnum_d;
				first_q <= first_d;
			end
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/dns_query_name_extractor_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// dns_query_name_extractor_core
// Extracts DNS query names from IPv4/UDP Ethernet frames, one byte per item.
// ---------------------------------------------------------------------------
//
// Channel   Dir  Handshake           Payload
// s_axis    in   tvalid/tready       tdata[7:0] frame byte, tlast frame end
// m_axis    out  tvalid/tready       tdata name byte/source ip/question index,
//                                    tlast name end, tuser byte_valid/truncated
// apb       in   psel/penable/pready reg 0 (addr 0x0): dns_port[15:0], reset 53
//
// One frame byte per clock unless stalled: an item is registered on entry,
// parsed from the input register, and its result (if any) lands in the
// output register; throughput is one item a cycle when nothing stalls.
// Bytes that give no result just update the parser state.
// Input stalls only while a result sits unclaimed in the output register and
// another item waits in the input register; the byte is not lost.
// Asynchronous reset clears the parser to the Ethernet header, empties both
// registers and sets dns_port to 53. Parser state also clears after tlast.
// ---------------------------------------------------------------------------
module dns_query_name_extractor_core
	import dnsqx_pkg::*;
#(
	parameter int unsigned POSITION_BITS = 16   // byte counter, 11..16
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	// frame bytes in
	input  wire logic                      s_axis_tvalid,
	output logic                           s_axis_tready,
	input  wire logic [7:0]                s_axis_tdata,   // [7:0] frame_byte
	input  wire logic                      s_axis_tlast,   // frame_end
	// name items out
	output logic                           m_axis_tvalid,
	input  wire logic                      m_axis_tready,
	output logic [OUT_TDATA_BITS-1:0]      m_axis_tdata,   // [7:0] name_byte,
	                                                       // [39:8] source_ip,
	                                                       // [55:40] question_index
	output logic                           m_axis_tlast,   // name_end
	output logic [OUT_TUSER_BITS-1:0]      m_axis_tuser,   // [0] byte_valid,
	                                                       // [1] truncated
	// configuration
	input  wire logic                      psel,
	input  wire logic                      penable,
	input  wire logic                      pwrite,
	input  wire logic [APB_ADDR_BITS-1:0]  paddr,
	input  wire logic [APB_DATA_BITS-1:0]  pwdata,
	output logic      [APB_DATA_BITS-1:0]  prdata,
	output logic                           pready
);

	logic [15:0] dns_port;

	// input register
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        end_s1;

	// output register
	logic        out_valid_q;
	result_t     out_q;

	result_t     res;
	logic        advance;

	dnsqx_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.dns_port (dns_port)
	);

	// the parsed byte moves on when the output register is free or draining
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
			end_s1  <= s_axis_tlast;
		end
	end

	dnsqx_parser #(
		.POSITION_BITS (POSITION_BITS)
	) u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.frame_byte (byte_s1),
		.frame_end  (end_s1),
		.dns_port   (dns_port),
		.result     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res.valid;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_q.question_index, out_q.source_ip, out_q.name_byte};
	assign m_axis_tlast  = out_q.name_end;
	assign m_axis_tuser  = {out_q.truncated, out_q.byte_valid};

endmodule
`default_nettype wire

// File: hw/rtl/dnsqx_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// dnsqx_checker
// Port-level checks on the extractor's streams, bound to the top level.
// ---------------------------------------------------------------------------
module dnsqx_checker
	import dnsqx_pkg::*;
(
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      s_axis_tready,
	input wire logic                      m_axis_tvalid,
	input wire logic                      m_axis_tready,
	input wire logic [OUT_TDATA_BITS-1:0] m_axis_tdata,
	input wire logic                      m_axis_tlast,
	input wire logic [OUT_TUSER_BITS-1:0] m_axis_tuser
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tlast) && $stable(m_axis_tuser))
		else $error("result changed while stalled");

	// a truncated name always closes the name
	a_trunc_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast)
		else $error("truncated without name end");

	// a character together with name end only on a cut-off frame
	a_char_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] && m_axis_tlast |-> m_axis_tuser[1])
		else $error("character and name end without truncation");

	// no character means a zero byte
	a_zero_byte: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[7:0] == 8'h00)
		else $error("name byte set without byte_valid");

	// with the output register empty, input is never stalled
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty output");

endmodule

bind dns_query_name_extractor_core dnsqx_checker u_dnsqx_checker (.*);
`default_nettype wire

// File: verif/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for dns_query_name_extractor_core: builds Ethernet /
// IPv4 / UDP / DNS frames, streams them byte by byte with random gaps and
// output stalls, and compares every name item against an in-bench parser.
// ---------------------------------------------------------------------------
module tb;
	import dnsqx_pkg::*;

	localparam int          ITEM_GOAL   = 600;     // bytes sent in the random part
	localparam int          PHASES      = 4;
	localparam int          WHOLE       = 32'h7fff_ffff;  // send the whole frame
	localparam int          DRAIN_LIMIT = 5000;
	localparam int          PIPE_SLACK  = 8;       // two-stage pipe plus margin
	localparam int          CYCLE_LIMIT = 4_000_000;
	localparam logic [15:0] ETYPE_IPV4  = {ETYPE_IPV4_HI, ETYPE_IPV4_LO};
	localparam logic [15:0] POS_MAX     = 16'hffff;
	localparam logic [APB_ADDR_BITS-1:0] PORT_ADDR = {REG_DNS_PORT, 2'b00};

	// parser phases: one per header layer, the name walk and an ignore phase
	typedef enum logic [3:0] {
		P_ETH_HDR, P_IP_HDR, P_UDP_HDR, P_DNS_HDR,
		P_LABEL_LEN, P_LABEL_CHR, P_TYPE_CLASS, P_IGNORE
	} parse_e;

	typedef enum logic [1:0] {EMIT_NONE, EMIT_CHAR, EMIT_DOT, EMIT_END} emit_e;

	// one frame to build; nlab < 0 picks 0..4 labels per name, lablen 0 picks
	// a random length per label; keep counts bytes past the DNS header
	typedef struct {
		logic [15:0] etype;
		logic [3:0]  ihl;
		logic [7:0]  proto;
		logic [31:0] src;
		logic [15:0] dport;
		logic [7:0]  flags;
		logic [15:0] qd;
		int          nnames;
		int          nlab;
		int          lablen;
		int          tail;
		int          keep;
		int          exp_items;    // -1: predictor only
	} frame_spec_t;

	logic                      clk;
	logic                      arst_n;
	logic                      s_axis_tvalid;
	logic                      s_axis_tready;
	logic [7:0]                s_axis_tdata;
	logic                      s_axis_tlast;
	logic                      m_axis_tvalid;
	logic                      m_axis_tready;
	logic [OUT_TDATA_BITS-1:0] m_axis_tdata;
	logic                      m_axis_tlast;
	logic [OUT_TUSER_BITS-1:0] m_axis_tuser;
	logic                      psel;
	logic                      penable;
	logic                      pwrite;
	logic [APB_ADDR_BITS-1:0]  paddr;
	logic [APB_DATA_BITS-1:0]  pwdata;
	logic [APB_DATA_BITS-1:0]  prdata;
	logic                      pready;

	dns_query_name_extractor_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hang guard: far above the slowest legal run
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("Regression FAIL");
		$finish;
	end

	// ------------------------------------------------------------------
	// Name parser model: mirrors the block's per-byte state
	// ------------------------------------------------------------------
	logic [15:0] port_cfg;
	logic [15:0] byte_cnt;
	parse_e      phase;
	logic [5:0]  ip_len;
	logic [31:0] src_acc;
	logic [15:0] dport_acc;
	logic [15:0] qd_left;
	logic [7:0]  chars_left;
	logic [2:0]  skip_left;
	logic [15:0] q_num;
	bit          at_name_start;

	result_t     name_q[$];     // name items still owed by the block
	int          err_cnt;
	int          rx_count;
	bit          quiet;         // no idling on either side

	function automatic void clear_frame();
		byte_cnt      = '0;
		phase         = P_ETH_HDR;
		ip_len        = '0;
		src_acc       = '0;
		dport_acc     = '0;
		qd_left       = '0;
		chars_left    = '0;
		skip_left     = '0;
		q_num         = '0;
		at_name_start = 1'b1;
	endfunction

	function automatic void note_error(input string msg);
		err_cnt++;
		if (err_cnt <= 10)
			$display("ERROR @%0t: %s", $realtime, msg);
	endfunction

	// Returns 1 when the byte produces a name item.
	function automatic bit parse_byte(input logic [7:0] b, input logic last,
			output result_t r);
		int unsigned off;
		emit_e       kind;
		logic [15:0] qidx;
		bit          open_name;
		bit          trunc;
		kind = EMIT_NONE;
		qidx = q_num;
		r    = '0;
		case (phase)
			P_ETH_HDR: begin
				if (byte_cnt == ETH_TYPE_HI_POS && b != ETYPE_IPV4_HI)
					phase = P_IGNORE;
				else if (byte_cnt == ETH_TYPE_LO_POS)
					phase = (b == ETYPE_IPV4_LO) ? P_IP_HDR : P_IGNORE;
			end
			P_IP_HDR: begin
				off = byte_cnt - ETH_HDR_BYTES;
				if (off == 0)
					ip_len = {b[3:0], 2'b00};
				if (off == 0 && ip_len < IP_IHL_MIN)
					phase = P_IGNORE;
				else if (off == IP_PROTO_OFF && b != IP_PROTO_UDP)
					phase = P_IGNORE;
				else begin
					if (off >= IP_SRC_FIRST && off <= IP_SRC_LAST)
						src_acc = {src_acc[23:0], b};
					if (off + 1 == ip_len)
						phase = P_UDP_HDR;
				end
			end
			P_UDP_HDR: begin
				off = byte_cnt - ETH_HDR_BYTES - ip_len;
				if (off == UDP_DPORT_HI)
					dport_acc = {b, 8'h00};
				else if (off == UDP_DPORT_LO) begin
					dport_acc[7:0] = b;
					if (dport_acc != port_cfg)
						phase = P_IGNORE;
				end else if (off == UDP_HDR_BYTES - 1)
					phase = P_DNS_HDR;
			end
			P_DNS_HDR: begin
				off = byte_cnt - ETH_HDR_BYTES - UDP_HDR_BYTES - ip_len;
				if (off == DNS_FLAGS_OFF && (b & DNS_QR_MASK) != 0)
					phase = P_IGNORE;
				else if (off == DNS_QDCNT_HI)
					qd_left = {b, 8'h00};
				else if (off == DNS_QDCNT_LO)
					qd_left[7:0] = b;
				else if (off == DNS_HDR_BYTES - 1) begin
					at_name_start = 1'b1;
					phase = (qd_left != 0) ? P_LABEL_LEN : P_IGNORE;
				end
			end
			P_LABEL_LEN: begin
				if (b == 0) begin
					kind          = EMIT_END;
					q_num         = q_num + 1'b1;
					qd_left       = qd_left - 1'b1;
					skip_left     = TRAILER_BYTES;
					at_name_start = 1'b1;
					phase         = P_TYPE_CLASS;
				end else begin
					chars_left = b;
					if (!at_name_start)
						kind = EMIT_DOT;
					at_name_start = 1'b0;
					phase = P_LABEL_CHR;
				end
			end
			P_LABEL_CHR: begin
				kind       = EMIT_CHAR;
				chars_left = chars_left - 1'b1;
				if (chars_left == 0)
					phase = P_LABEL_LEN;
			end
			P_TYPE_CLASS: begin
				skip_left = skip_left - 1'b1;
				if (skip_left == 0)
					phase = (qd_left != 0) ? P_LABEL_LEN : P_IGNORE;
			end
			default: ;
		endcase

		if (byte_cnt != POS_MAX)
			byte_cnt = byte_cnt + 1'b1;

		// frame cut while a name is open closes it as truncated
		open_name = last && (phase == P_LABEL_CHR ||
				(phase == P_LABEL_LEN && !at_name_start));
		parse_byte = (kind != EMIT_NONE) || open_name;
		if (parse_byte) begin
			trunc            = open_name && kind != EMIT_END;
			r.valid          = 1'b1;
			r.truncated      = trunc;
			r.source_ip      = src_acc;
			r.question_index = qidx;
			if (kind == EMIT_CHAR) begin
				r.name_byte  = b;
				r.byte_valid = 1'b1;
			end else if (kind == EMIT_DOT && !trunc) begin
				// a dot pending when the frame ends is dropped
				r.name_byte  = NAME_DOT;
				r.byte_valid = 1'b1;
			end
			r.name_end = (kind == EMIT_END) || trunc;
		end
		if (last)
			clear_frame();
	endfunction

	// ------------------------------------------------------------------
	// Monitor: predict on every accepted input byte, check every output item
	// ------------------------------------------------------------------
	always @(posedge clk) begin : monitor
		result_t want;
		result_t got;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				if (parse_byte(s_axis_tdata, s_axis_tlast, want))
					name_q.push_back(want);
			if (m_axis_tvalid && m_axis_tready) begin
				rx_count++;
				got                = '0;
				got.valid          = 1'b1;
				got.name_byte      = m_axis_tdata[7:0];
				got.source_ip      = m_axis_tdata[39:8];
				got.question_index = m_axis_tdata[55:40];
				got.name_end       = m_axis_tlast;
				got.byte_valid     = m_axis_tuser[0];
				got.truncated      = m_axis_tuser[1];
				if (name_q.size() == 0)
					note_error($sformatf("unexpected item chr=%h bv=%b end=%b tr=%b ip=%h q=%0d",
						got.name_byte, got.byte_valid, got.name_end, got.truncated,
						got.source_ip, got.question_index));
				else begin
					want = name_q.pop_front();
					if (got.name_byte !== want.name_byte ||
							got.byte_valid !== want.byte_valid ||
							got.name_end !== want.name_end ||
							got.truncated !== want.truncated ||
							got.source_ip !== want.source_ip ||
							got.question_index !== want.question_index)
						note_error($sformatf(
							"exp chr=%h bv=%b end=%b tr=%b ip=%h q=%0d / got chr=%h bv=%b end=%b tr=%b ip=%h q=%0d",
							want.name_byte, want.byte_valid, want.name_end, want.truncated,
							want.source_ip, want.question_index,
							got.name_byte, got.byte_valid, got.name_end, got.truncated,
							got.source_ip, got.question_index));
				end
			end
		end
	end

	// Output side: random stall bursts, off while quiet.
	int unsigned rx_hold;
	always @(posedge clk) begin
		if (rx_hold != 0) begin
			rx_hold       <= rx_hold - 1;
			m_axis_tready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 9) == 0) begin
			rx_hold       <= $urandom_range(0, 8);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers; all of them start and end on a rising edge
	// ------------------------------------------------------------------
	logic [7:0] frame_q[$];
	int         hdr_len;       // bytes up to the end of the DNS header

	task automatic push_byte(input logic [7:0] b, input logic last);
		if (!quiet && $urandom_range(0, 7) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= last;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	// Waits for every owed item, then lets the pipe empty.
	task automatic settle();
		int waited;
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		waited = 0;
		while (name_q.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (name_q.size() != 0) begin
			note_error($sformatf("%0d name items never arrived", name_q.size()));
			name_q.delete();
		end
		repeat (PIPE_SLACK) @(posedge clk);
	endtask

	task automatic write_port(input logic [15:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PORT_ADDR;
		pwdata  <= {16'h0000, v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		port_cfg = v;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic check_port(input logic [15:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= PORT_ADDR;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata[15:0] !== v)
			note_error($sformatf("dns_port read %h, exp %h", prdata[15:0], v));
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	function automatic void add_name(input int nlab, input int lablen);
		int labels;
		int n;
		labels = (nlab < 0) ? $urandom_range(0, 4) : nlab;
		for (int l = 0; l < labels; l++) begin
			if (lablen > 0)
				n = lablen;
			else if ($urandom_range(0, 19) == 0)
				n = $urandom_range(63, 255);
			else
				n = $urandom_range(1, 12);
			frame_q.push_back(8'(n));
			repeat (n) frame_q.push_back(8'($urandom));
		end
		frame_q.push_back(8'h00);
		repeat (4) frame_q.push_back(8'($urandom));    // type and class
	endfunction

	function automatic void load_frame(input frame_spec_t f);
		int hb;
		frame_q.delete();
		hb = ((f.ihl < 5) ? 5 : f.ihl) * 4;
		repeat (12) frame_q.push_back(8'($urandom));   // MAC addresses
		frame_q.push_back(f.etype[15:8]);
		frame_q.push_back(f.etype[7:0]);
		frame_q.push_back({4'($urandom), f.ihl});
		for (int i = 1; i < hb; i++) begin
			if (i == IP_PROTO_OFF)
				frame_q.push_back(f.proto);
			else if (i >= IP_SRC_FIRST && i <= IP_SRC_LAST)
				frame_q.push_back(f.src[8 * (IP_SRC_LAST - i) +: 8]);
			else
				frame_q.push_back(8'($urandom));
		end
		repeat (2) frame_q.push_back(8'($urandom));    // source port
		frame_q.push_back(f.dport[15:8]);
		frame_q.push_back(f.dport[7:0]);
		repeat (4) frame_q.push_back(8'($urandom));    // length, checksum
		repeat (2) frame_q.push_back(8'($urandom));    // DNS id
		frame_q.push_back(f.flags);
		frame_q.push_back(8'($urandom));
		frame_q.push_back(f.qd[15:8]);
		frame_q.push_back(f.qd[7:0]);
		repeat (6) frame_q.push_back(8'($urandom));    // other counts
		hdr_len = frame_q.size();
		for (int k = 0; k < f.nnames; k++)
			add_name(f.nlab, f.lablen);
		repeat (f.tail) frame_q.push_back(8'($urandom));
	endfunction

	task automatic send_frame(input int keep, output int sent);
		int total;
		total = (keep == WHOLE) ? frame_q.size() : hdr_len + keep;
		if (total > frame_q.size())
			total = frame_q.size();
		if (total < 1)
			total = 1;
		for (int i = 0; i < total; i++)
			push_byte(frame_q[i], i == total - 1);
		sent = total;
	endtask

	// Mostly well-formed queries with random content; the rest is broken
	// headers and raw noise.
	task automatic random_frame(output int sent);
		frame_spec_t f;
		int          pick;
		bit          well;
		f = '{ETYPE_IPV4, 4'd5, IP_PROTO_UDP, 32'($urandom), port_cfg,
			8'($urandom) & ~DNS_QR_MASK, 16'($urandom_range(1, 3)),
			0, -1, 0, 0, WHOLE, -1};
		if ($urandom_range(0, 7) == 0)
			f.src = $urandom_range(0, 1) ? '1 : '0;
		if ($urandom_range(0, 3) == 0)
			f.ihl = 4'($urandom_range(6, 15));
		f.nnames = f.qd;
		case ($urandom_range(0, 9))
			0: f.qd = 16'($urandom);                      // runs past the names
			1: f.nnames = f.qd + $urandom_range(1, 2);   // surplus names ignored
			2: f.qd = '0;
			default: ;
		endcase
		if ($urandom_range(0, 3) == 0)
			f.tail = $urandom_range(1, 8);
		pick = $urandom_range(0, 9);
		well = (pick < 8);
		if (pick == 9) begin
			// raw noise, half of it past the EtherType check
			frame_q.delete();
			repeat ($urandom_range(1, 100)) frame_q.push_back(8'($urandom));
			if (frame_q.size() > ETH_TYPE_LO_POS && $urandom_range(0, 1)) begin
				frame_q[ETH_TYPE_HI_POS] = ETYPE_IPV4_HI;
				frame_q[ETH_TYPE_LO_POS] = ETYPE_IPV4_LO;
			end
			hdr_len = 0;
		end else begin
			if (pick == 8) begin
				case ($urandom_range(0, 5))
					0: f.etype = ETYPE_IPV4 ^ 16'($urandom_range(1, 65535));
					1: f.ihl = 4'($urandom_range(0, 4));
					2: f.proto = IP_PROTO_UDP ^ 8'($urandom_range(1, 255));
					3: f.dport = port_cfg ^ 16'($urandom_range(1, 65535));
					4: f.flags = f.flags | DNS_QR_MASK;
					default: f.keep = -1;    // cut inside the headers below
				endcase
			end
			load_frame(f);
			if (f.keep == -1)
				f.keep = -$urandom_range(1, hdr_len - 1);
			else if (well && $urandom_range(0, 3) == 0)
				f.keep = $urandom_range(0, frame_q.size() - hdr_len);
		end
		send_frame(f.keep, sent);
	endtask

	// ------------------------------------------------------------------
	// Directed frames: header rejects, name shapes, cut points
	// ------------------------------------------------------------------
	frame_spec_t dir_tab[23];

	initial begin : stim
		logic [15:0] port_plan[PHASES];
		int          rx_start;
		int          sent;
		int          items;
		int          goal;
		int          frames;
		int          bytes;

		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tlast  = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		quiet         = 1'b0;
		err_cnt       = 0;
		rx_count      = 0;
		items         = 0;
		goal          = 0;
		frames        = 0;
		bytes         = 0;
		port_cfg      = DNS_PORT_RESET;
		clear_frame();

		//  etype       ihl    proto         src            dport           flags
		//  qd      names lab len tail keep   items
		dir_tab = '{
			'{ETYPE_IPV4, 4'd5, IP_PROTO_UDP, 32'hc0a8_0001, DNS_PORT_RESET, 8'h01,
				16'd1, 1, 3, 3, 0, WHOLE, 12},    // a.b.c style name
			'{16'h86dd, 4'd5, IP_PROTO_UDP, 32'h0a00_0001, DNS_PORT_RESET, 8'h01,
				16'd1, 1, 2, 3, 0, WHOLE, 0},     // EtherType high byte wrong
			'{16'h0806, 4'd5, IP_PROTO_UDP, 32'h0a00_0001, DNS_PORT_RESET, 8'h01,
				16'd1, 1, 2, 3, 0, WHOLE, 0},     // EtherType low byte wrong
			'{ETYPE_IPV4, 4'd4, IP_PROTO_UDP, 32'h0a00_0002, DNS_PORT_RESET, 8'h01,
				16'd1, 1, 2, 3, 0, WHOLE, 0},     // header length below 20
			'{ETYPE_IPV4, 4'd0, IP_PROTO_UDP, 32'h0a00_0002, DNS_PORT_RESET, 8'h01,
				16'd1, 1, 2, 3, 0, WHOLE, 0},
			'{ETYPE_IPV4, 4'd15, IP_PROTO_UDP, 32'hffff_ffff, DNS_PORT_RESET, 8'h00,
				16'd1, 1, 1, 1, 0, WHOLE, 2},     // full options, one character
			'{ETYPE_IPV4, 4'd5, 8'd6, 32'h0a00_0003, DNS_PORT_RESET, 8'h01,
				16'd1, 1, 2, 3, 0, WHOLE, 0},     // TCP
			'{ETYPE_IPV4, 4'd5, IP_PROTO_UDP, 32'h0a00_0003, 16'd54, 8'h01,
				16'd1, 1, 2, 3, 0, WHOLE, 0},     // other port
			'{ETYPE_IPV4, 4'd5, IP_PROTO_UDP, 32'h0a00_0004, DNS_PORT_RESET, 8'h80,
				16'd1, 1, 2, 3, 0, WHOLE, 0},     // response, QR set
			'{ETYPE_IPV4, 4'd5, IP_PROTO_UDP, 32'h0000_0000, DNS_PORT_RESET, 8'h7f,
				16'd1, 1, 2, 2, 0, WHOLE, 6},     // every flag but QR
			'{ETYPE_IPV4, 4'd5, IP_PROTO_UDP, 32'h0a00_0005, DNS_PORT_RESET, 8'h01,
				16'd0, 1, 2, 3, 0, WHOLE, 0},     // no questions
			'{ETYPE_IPV4, 4'd5, IP_PROTO_UDP, 32'h0a00_0006, DNS_PORT_RESET, 8'h01,
				16'd1, 1, 0, 0, 0, WHOLE, 1},     // root name, end marker only
			'{ETYPE_IPV4, 4'd5, IP_PROTO_UDP, 32'h0a00_0007, DNS_PORT_RESET, 8'h01,
				16'd1, 1, 1, 255, 0, WHOLE, 256}, // longest label
			'{ETYPE_IPV4, 4'd5, IP_PROTO_UDP, 32'h0a00_0008, DNS_PORT_RESET, 8'h01,
				16'd3, 3, 2, 1, 0, WHOLE, 12},    // three questions
			'{ETYPE_IPV4, 4'd5, IP_PROTO_UDP, 32'h0a00_0009, DNS_PORT_RESET, 8'h01,
				16'd1, 1, 2, 4, 0, 3, -1},        // cut inside a label
			'{ETYPE_IPV4, 4'd5, IP_PROTO_UDP, 32'h0a00_000a, DNS_PORT_RESET, 8'h01,
				16'd1, 1, 2, 4, 0, 6, -1},        // cut on a length byte, dot dropped
			'{ETYPE_IPV4, 4'd5, IP_PROTO_UDP, 32'h0a00_000b, DNS_PORT_RESET, 8'h01,
				16'd1, 1, 2, 4, 0, 5, -1},        // cut on last character of a label
			'{ETYPE_IPV4, 4'd5, IP_PROTO_UDP, 32'h0a00_000c, DNS_PORT_RESET, 8'h01,
				16'd1, 1, 1, 2, 0, 6, -1},        // cut inside type/class
			'{ETYPE_IPV4, 4'd5, IP_PROTO_UDP, 32'h0a00_000d, DNS_PORT_RESET, 8'h01,
				16'd1, 1, 1, 2, 0, -3, 0},        // cut inside the DNS header
			'{ETYPE_IPV4, 4'd5, IP_PROTO_UDP, 32'h0a00_000e, DNS_PORT_RESET, 8'h01,
				16'd1, 1, 1, 2, 0, -53, 0},       // one-byte frame
			'{ETYPE_IPV4, 4'd5, IP_PROTO_UDP, 32'h0a00_000f, DNS_PORT_RESET, 8'h01,
				16'd1, 1, 1, 3, 10, WHOLE, 4},    // trailing bytes ignored
			'{ETYPE_IPV4, 4'd5, IP_PROTO_UDP, 32'h0a00_0010, DNS_PORT_RESET, 8'h01,
				16'hffff, 2, 1, 2, 0, WHOLE, -1}, // count beyond the frame
			'{ETYPE_IPV4, 4'd5, IP_PROTO_UDP, 32'h0a00_0011, DNS_PORT_RESET, 8'h01,
				16'd1, 1, 1, 5, 0, 1, -1}         // cut on the first length byte
		};

		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		check_port(DNS_PORT_RESET);

		foreach (dir_tab[i]) begin
			rx_start = rx_count;
			load_frame(dir_tab[i]);
			send_frame(dir_tab[i].keep, sent);
			settle();    // sender holds off until every owed item is in
			frames++;
			bytes += sent;
			if (dir_tab[i].exp_items >= 0 && rx_count - rx_start != dir_tab[i].exp_items)
				note_error($sformatf("frame %0d: %0d name items, exp %0d",
					i, rx_count - rx_start, dir_tab[i].exp_items));
		end

		// port extremes first; the last phase runs without idling
		port_plan = '{16'h0000, 16'hffff, 16'($urandom_range(1, 65534)), DNS_PORT_RESET};
		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			quiet = (ph == PHASES - 1);
			write_port(port_plan[ph]);
			check_port(port_plan[ph]);
			goal += ITEM_GOAL / PHASES;
			while (items < goal) begin
				random_frame(sent);
				frames++;
				bytes += sent;
				items += sent;
			end
		end
		settle();

		$display("Covered %0d frames, %0d bytes, %0d name items checked,", frames, bytes,
			rx_count);
		$display("over %0d dns_port settings with random gaps and stalls.", PHASES + 1);
		if (err_cnt == 0) begin
			$display("Regression PASS");
		end else begin
			$display("%0d mismatches", err_cnt);
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
